// ----- hdl/tpbm_pkg.sv -----
// Shared types, constants and the bin edge table of the tone period bin meter.
// Used by tpbm_lane, tpbm_merge and tone_period_bin_meter_unit.
// No dependencies.
package tpbm_pkg;

    // Number of bars, the index widths that follow from it and the bin index field width.
    localparam int BIN_COUNT   = 32;
    localparam int BIN_W       = $clog2(BIN_COUNT);
    localparam int EDGE_IDX_W  = $clog2(BIN_COUNT + 1);
    localparam int BIN_IDX_W   = 6;

    // Field widths of one frame.
    localparam int PERIOD_W     = 12;
    localparam int AMP_W        = 5;
    localparam int NUM_CHIPS    = 2;
    localparam int CH_PER_CHIP  = 3;
    localparam int NUM_LANES    = NUM_CHIPS * CH_PER_CHIP;
    localparam int CHIP_FIELD_W = CH_PER_CHIP * (PERIOD_W + AMP_W);
    localparam int IN_FIELD_W   = NUM_CHIPS * CHIP_FIELD_W;
    localparam int IN_TDATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = 32;

    // Peak hold: signed, decays by (full scale + 1) / 16 per frame.
    localparam int PEAK_W     = 6;
    localparam int FULL_SCALE = 31;
    localparam int DECAY_STEP = (FULL_SCALE + 1) / 16;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_IDX_DUAL_MODE = 1'b0;

    // Logarithmic bin edges from 0xFFF down to 0xFFF * 1773400 / (16 * 22050 * 0xFFF),
    // rounded to the nearest integer. Bin i holds periods in (edge[i+1], edge[i]].
    localparam logic [PERIOD_W-1:0] BIN_EDGES [0:BIN_COUNT] = '{
        12'd4095, 12'd3321, 12'd2694, 12'd2184, 12'd1772, 12'd1437, 12'd1165,
        12'd945,  12'd766,  12'd622,  12'd504,  12'd409,  12'd332,  12'd269,
        12'd218,  12'd177,  12'd143,  12'd116,  12'd94,   12'd77,   12'd62,
        12'd50,   12'd41,   12'd33,   12'd27,   12'd22,   12'd18,   12'd14,
        12'd12,   12'd9,    12'd8,    12'd6,    12'd5
    };

    typedef logic [AMP_W-1:0]    t_amp;
    typedef logic [PERIOD_W-1:0] t_period;
    typedef logic [BIN_W-1:0]    t_bin;

    // One bin step handed from the sequencer to the merging stage.
    typedef struct packed {
        logic valid;
        t_bin bin;
    } t_bin_step;

    // What the merging stage found for one bin.
    typedef struct packed {
        t_amp bar;
        logic shown;
        t_amp mark;
    } t_bin_result;

endpackage

// ----- hdl/tpbm_lane.sv -----
// One channel lane: tests whether its tone period falls in the current bin.
// Depends on tpbm_pkg for the edge table and the field types.
module tpbm_lane (
    input  tpbm_pkg::t_bin    i_bin,
    input  tpbm_pkg::t_period i_period,
    input  tpbm_pkg::t_amp    i_amp,
    output tpbm_pkg::t_amp    o_hit_amp
);
    import tpbm_pkg::*;

    logic [EDGE_IDX_W-1:0] hi_idx;
    logic [EDGE_IDX_W-1:0] lo_idx;
    t_period               hi_edge;
    t_period               lo_edge;
    logic                  hit;

    // The upper edge of bin i is entry i, the lower (exclusive) one entry i+1.
    assign hi_idx  = EDGE_IDX_W'(i_bin);
    assign lo_idx  = hi_idx + EDGE_IDX_W'(1);
    assign hi_edge = BIN_EDGES[hi_idx];
    assign lo_edge = BIN_EDGES[lo_idx];
    assign hit     = (i_period > lo_edge) && (i_period <= hi_edge);

    assign o_hit_amp = hit ? i_amp : '0;

endmodule

// ----- hdl/tpbm_merge.sv -----
// Merging stage: takes the largest lane amplitude as the bar level and keeps
// the per-bin peak hold. Depends on tpbm_pkg.
module tpbm_merge (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tpbm_pkg::t_bin_step    i_step,
    input  tpbm_pkg::t_amp         i_lane_amp [tpbm_pkg::NUM_LANES],
    output tpbm_pkg::t_bin_result  o_result
);
    import tpbm_pkg::*;

    logic signed [PEAK_W-1:0] r_peak [BIN_COUNT];
    logic signed [PEAK_W-1:0] n_peak;
    logic signed [PEAK_W-1:0] peak_cur;
    logic signed [PEAK_W-1:0] fresh_s;
    t_amp                     fresh;
    logic                     above;

    always_comb begin
        fresh = '0;
        for (int l = 0; l < NUM_LANES; l++) begin
            if (i_lane_amp[l] > fresh) begin
                fresh = i_lane_amp[l];
            end
        end
    end

    assign peak_cur = r_peak[i_step.bin];
    assign fresh_s  = $signed({1'b0, fresh});
    assign above    = peak_cur > fresh_s;

    // While the held peak stays above the fresh level it decays, else it reloads.
    assign n_peak = above ? (peak_cur - PEAK_W'(DECAY_STEP)) : fresh_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < BIN_COUNT; b++) begin
                r_peak[b] <= '0;
            end
        end else if (i_step.valid) begin
            r_peak[i_step.bin] <= n_peak;
        end
    end

    assign o_result.bar   = fresh;
    assign o_result.shown = above;
    assign o_result.mark  = above ? peak_cur[AMP_W-1:0] : '0;

endmodule

// ----- hdl/tone_period_bin_meter_unit.sv -----
// Top level of the tone period bin meter: stream ports, frame register, bin
// sequencer, six channel lanes and the merging stage. Depends on tpbm_pkg,
// tpbm_lane and tpbm_merge.
//
//   Channel   Direction  Handshake                  Payload
//   s_axis    in         s_axis_tvalid/tready       one frame: six periods, six amplitudes
//   m_axis    out        m_axis_tvalid/tready       one bar per item, tlast on the last bar
//   APB       in         psel, penable, pwrite      register 0: dual_chip_mode
//
// A frame gives BIN_COUNT (32) result items, one bar per cycle while the output
// register can take it: once the frame has entered the frame register, the bin
// sequencer walks the bins once and all six lanes test their period against
// the current bin in parallel. The next frame is accepted once the last bar of
// the current one has moved into the output register. Any cycle in which the
// output register is full and not taken holds the sequencer. Reset is
// synchronous and clears the peak holds, the mode bit and all handshake state.
module tone_period_bin_meter_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Frame input. tdata fields from bit 0 up: chip0_period_a, chip0_period_b,
    // chip0_period_c, chip0_amp_a, chip0_amp_b, chip0_amp_c, chip1_period_a,
    // chip1_period_b, chip1_period_c, chip1_amp_a, chip1_amp_b, chip1_amp_c,
    // then zero fill.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [tpbm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // Bar output. tdata fields from bit 0 up: bin_index, bar_level,
    // marker_shown, marker_level, level_a, level_b, level_c.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [tpbm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                               m_axis_tlast,
    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tpbm_pkg::PADDR_W-1:0]       paddr,
    input  logic [tpbm_pkg::PDATA_W-1:0]       pwdata,
    output logic [tpbm_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);
    import tpbm_pkg::*;

    // Configuration register. Registers are word spaced, so the word index
    // starts at address bit 2.
    logic r_dual;
    logic cfg_write;
    logic reg_idx;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dual <= 1'b0;
        end else if (cfg_write && (reg_idx == REG_IDX_DUAL_MODE)) begin
            r_dual <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_IDX_DUAL_MODE) begin
            prdata[0] = r_dual;
        end
    end

    // Frame register. In single-chip mode the second chip's amplitudes are
    // stored as zero: a silent channel feeds no bin and no channel level.
    t_period r_period [NUM_LANES];
    t_amp    r_amp    [NUM_LANES];
    t_amp    r_lev    [CH_PER_CHIP];
    t_amp    in_amp   [NUM_LANES];
    t_period in_period[NUM_LANES];
    logic    in_accept;

    always_comb begin
        for (int c = 0; c < NUM_CHIPS; c++) begin
            for (int h = 0; h < CH_PER_CHIP; h++) begin
                in_period[c*CH_PER_CHIP + h] =
                    s_axis_tdata[c*CHIP_FIELD_W + h*PERIOD_W +: PERIOD_W];
                in_amp[c*CH_PER_CHIP + h] =
                    s_axis_tdata[c*CHIP_FIELD_W + CH_PER_CHIP*PERIOD_W + h*AMP_W +: AMP_W];
                if (c != 0 && !r_dual) begin
                    in_amp[c*CH_PER_CHIP + h] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                r_period[l] <= in_period[l];
                r_amp[l]    <= in_amp[l];
            end
            for (int h = 0; h < CH_PER_CHIP; h++) begin
                r_lev[h] <= (in_amp[CH_PER_CHIP + h] > in_amp[h]) ?
                            in_amp[CH_PER_CHIP + h] : in_amp[h];
            end
        end
    end

    // Bin sequencer. One bar is produced in every cycle that the output
    // register can take it.
    logic      r_busy;
    t_bin      r_bin;
    logic      out_free;
    logic      last_step;
    t_bin_step step;

    assign s_axis_tready = !r_busy;
    assign in_accept     = s_axis_tvalid && !r_busy;
    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign step.valid    = r_busy && out_free;
    assign step.bin      = r_bin;
    assign last_step     = (r_bin == t_bin'(BIN_COUNT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_bin  <= '0;
        end else if (in_accept) begin
            r_busy <= 1'b1;
            r_bin  <= '0;
        end else if (step.valid) begin
            r_bin <= r_bin + t_bin'(1);
            if (last_step) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Six lanes test their channel against the current bin side by side.
    t_amp        lane_amp [NUM_LANES];
    t_bin_result result;

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        tpbm_lane u_lane (
            .i_bin     (r_bin),
            .i_period  (r_period[l]),
            .i_amp     (r_amp[l]),
            .o_hit_amp (lane_amp[l])
        );
    end

    tpbm_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_lane_amp (lane_amp),
        .o_result   (result)
    );

    // Output register: it parts the bar stream from the sequencer.
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step.valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step.valid) begin
            r_out_data <= {r_lev[2], r_lev[1], r_lev[0], result.mark, result.shown,
                           result.bar, BIN_IDX_W'(r_bin)};
            r_out_last <= last_step;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

// ----- tb/sv/tone_period_bin_meter_unit_tb.sv -----
// Self-checking testbench for tone_period_bin_meter_unit: frames in, one bar per bin out.
// Holds its own bin edge table and peak-hold model and compares every bar field.
// Depends on tpbm_pkg and tone_period_bin_meter_unit.
module tone_period_bin_meter_unit_tb;

    import tpbm_pkg::*;

    // Constants that define the logarithmic bin edges.
    localparam logic [63:0] CHIP_CLOCK_HZ  = 64'd1773400;
    localparam logic [63:0] SAMPLE_RATE_HZ = 64'd22050;
    localparam logic [63:0] OVERSAMPLING   = 64'd16;
    localparam logic [63:0] LONGEST_PERIOD = 64'd4095;
    localparam logic [63:0] Q62_ONE        = 64'd1 << 62;

    // The held peak drops by (31 + 1) / 16 per frame while it is above the bar.
    localparam int PEAK_DECAY = 2;

    // Register addresses: register i sits at byte address 4 * i.
    localparam logic [PADDR_W-1:0] ADDR_DUAL_MODE = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED  = 3'd4;

    localparam int SHOWN_MISMATCHES = 10;

    // One chip's registers and a whole frame, packed as on s_axis_tdata.
    typedef struct packed {
        t_amp    [CH_PER_CHIP-1:0] amp;
        t_period [CH_PER_CHIP-1:0] period;
    } t_chip_regs;
    typedef t_chip_regs [NUM_CHIPS-1:0] t_frame_regs;

    // One bar as on m_axis_tdata, lowest field last.
    typedef struct packed {
        t_amp       level_c;
        t_amp       level_b;
        t_amp       level_a;
        t_amp       marker_level;
        logic       marker_shown;
        t_amp       bar_level;
        logic [5:0] bin_index;
    } t_bar_word;

    typedef struct {
        t_bar_word word;
        logic      last;
    } t_bar_item;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [PADDR_W-1:0]     paddr         = '0;
    logic [PDATA_W-1:0]     pwdata        = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    // Model state: edge table, held peaks, mode bit.
    logic [PERIOD_W-1:0] bar_edge [0:BIN_COUNT];
    int                  peak_level [BIN_COUNT];
    logic                dual_mode_model = 1'b0;

    t_bar_item pending_bars[$];
    int        fault_count   = 0;
    int        send_idle_pct = 33;
    int        recv_idle_pct = 66;

    tone_period_bin_meter_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tone_period_bin_meter_unit_tb: done, errors");
        $finish;
    end

    // Fixed point helpers for the edge table, values in Q62.
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    function automatic logic [63:0] q62_pow(input logic [63:0] q, input int n);
        logic [63:0] p;
        p = Q62_ONE;
        for (int k = 0; k < n; k++) begin
            p = q62_mul(p, q);
        end
        return p;
    endfunction

    // The edges fall geometrically from the longest period by a ratio q chosen as
    // the largest q whose BIN_COUNT-th power stays at or below the span ratio.
    function automatic void build_bar_edges();
        logic [127:0] num;
        logic [63:0]  den, span, lo, hi, mid, p, v;
        den  = OVERSAMPLING * SAMPLE_RATE_HZ * LONGEST_PERIOD;
        num  = {64'd0, CHIP_CLOCK_HZ} << 62;
        span = 64'(num / {64'd0, den});
        lo   = '0;
        hi   = Q62_ONE;
        while (hi - lo > 64'd1) begin
            mid = lo + (hi - lo) / 64'd2;
            if (q62_pow(mid, BIN_COUNT) <= span) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        bar_edge[0] = PERIOD_W'(LONGEST_PERIOD);
        p = Q62_ONE;
        for (int k = 1; k <= BIN_COUNT; k++) begin
            p = q62_mul(p, lo);
            v = (p >> 20) * LONGEST_PERIOD;
            bar_edge[k] = PERIOD_W'((v + (64'd1 << 41)) >> 42);
        end
    endfunction

    // Works out the BIN_COUNT bars of one frame and queues them.
    function automatic void meter_frame(input t_frame_regs f);
        int        fresh [BIN_COUNT];
        int        lvl [CH_PER_CHIP];
        int        chips, amp;
        t_bar_item bar;
        foreach (fresh[b]) fresh[b] = 0;
        for (int c = 0; c < CH_PER_CHIP; c++) lvl[c] = int'(f[0].amp[c]);
        chips = dual_mode_model ? 2 : 1;
        for (int ch = 0; ch < chips; ch++) begin
            for (int c = 0; c < CH_PER_CHIP; c++) begin
                amp = int'(f[ch].amp[c]);
                for (int b = 0; b < BIN_COUNT; b++) begin
                    if (f[ch].period[c] > bar_edge[b+1] && f[ch].period[c] <= bar_edge[b]
                        && fresh[b] < amp) begin
                        fresh[b] = amp;
                    end
                end
                if (amp > lvl[c]) lvl[c] = amp;
            end
        end
        for (int b = 0; b < BIN_COUNT; b++) begin
            bar.word.bin_index = 6'(b);
            bar.word.bar_level = t_amp'(fresh[b]);
            bar.word.level_a   = t_amp'(lvl[0]);
            bar.word.level_b   = t_amp'(lvl[1]);
            bar.word.level_c   = t_amp'(lvl[2]);
            bar.last           = (b == BIN_COUNT - 1);
            // A peak above the bar shows as a marker, then decays; a peak that has
            // gone below zero never shows and is reloaded.
            if (peak_level[b] > fresh[b]) begin
                bar.word.marker_shown = 1'b1;
                bar.word.marker_level = t_amp'(peak_level[b]);
                peak_level[b] -= PEAK_DECAY;
            end else begin
                bar.word.marker_shown = 1'b0;
                bar.word.marker_level = '0;
                peak_level[b] = fresh[b];
            end
            pending_bars.push_back(bar);
        end
    endfunction

    task automatic note_fault(input string what, input int want, input int got);
        fault_count++;
        if (fault_count <= SHOWN_MISMATCHES) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) note_fault(what, want, got);
    endtask

    // Receiver: tready stalls at random with the current idle share.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Each bar taken from the block is compared with the oldest expected bar.
    always @(posedge i_clk) begin : check_bars
        t_bar_item want;
        t_bar_word got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_bars.size() == 0) begin
                note_fault("unexpected bar, bin", -1, int'(got.bin_index));
            end else begin
                want = pending_bars.pop_front();
                check_field("bin_index", want.word.bin_index, got.bin_index);
                check_field("bar_level", want.word.bar_level, got.bar_level);
                check_field("marker_shown", want.word.marker_shown, got.marker_shown);
                check_field("marker_level", want.word.marker_level, got.marker_level);
                check_field("level_a", want.word.level_a, got.level_a);
                check_field("level_b", want.word.level_b, got.level_b);
                check_field("level_c", want.word.level_c, got.level_c);
                check_field("last_bin", want.last, m_axis_tlast);
            end
        end
    end

    // Offers one frame, with random idle cycles ahead of it, and predicts its
    // bars once the block has taken it.
    task automatic send_frame(input t_frame_regs f);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(f);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        meter_frame(f);
    endtask

    // Waits until every expected bar is out and the block has settled.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_bars.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_DUAL_MODE) dual_mode_model = data[0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read_check(input logic [PADDR_W-1:0] addr,
                                  input logic [PDATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== want) note_fault("register read", int'(want), int'(prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_period rand_period();
        int sel, k;
        sel = $urandom_range(9);
        if (sel <= 5) begin
            // Anywhere inside one bin, so the short-period bins get traffic too.
            k = $urandom_range(BIN_COUNT - 1);
            return t_period'($urandom_range(int'(bar_edge[k]), int'(bar_edge[k+1]) + 1));
        end else if (sel <= 7) begin
            return t_period'($urandom_range(4095));
        end else if (sel == 8) begin
            return t_period'($urandom_range(int'(bar_edge[BIN_COUNT])));
        end
        return bar_edge[$urandom_range(BIN_COUNT)];
    endfunction

    function automatic t_frame_regs rand_frame();
        t_frame_regs f;
        logic        silent;
        silent = ($urandom_range(99) < 15);
        for (int ch = 0; ch < NUM_CHIPS; ch++) begin
            for (int c = 0; c < CH_PER_CHIP; c++) begin
                f[ch].period[c] = rand_period();
                if (silent || $urandom_range(3) == 0) begin
                    f[ch].amp[c] = '0;
                end else begin
                    f[ch].amp[c] = t_amp'($urandom_range(31));
                end
            end
        end
        return f;
    endfunction

    // Every edge value and the period just above it, six channels per frame in
    // dual mode; the top edge plus one wraps to period zero.
    task automatic test_bin_edges();
        t_frame_regs f;
        int          idx, k;
        wait_idle();
        apb_write(ADDR_DUAL_MODE, 32'd1);
        apb_read_check(ADDR_DUAL_MODE, 32'd1);
        for (int j = 0; j < 11; j++) begin
            for (int n = 0; n < NUM_LANES; n++) begin
                idx = j * NUM_LANES + n;
                k   = idx / 2;
                f[n / CH_PER_CHIP].period[n % CH_PER_CHIP] =
                    (idx % 2 == 0) ? bar_edge[k] : bar_edge[k] + 1'b1;
                f[n / CH_PER_CHIP].amp[n % CH_PER_CHIP] = t_amp'(31 - ((idx * 5) % 32));
            end
            send_frame(f);
        end
    endtask

    // A full-scale frame, then a frame with small peaks, then silent frames so
    // the markers decay, one of them below zero and back.
    task automatic test_peak_decay();
        t_frame_regs f;
        wait_idle();
        apb_write(ADDR_DUAL_MODE, 32'd0);
        f = '1;
        send_frame(f);
        f = '0;
        f[0].period[0] = bar_edge[2];
        f[0].amp[0]    = 5'd5;
        f[0].period[1] = bar_edge[10];
        f[0].amp[1]    = 5'd1;
        f[0].period[2] = '0;
        f[0].amp[2]    = 5'd31;
        f[1]           = '1;
        send_frame(f);
        f = '0;
        repeat (4) send_frame(f);
    endtask

    // Chip 1 is ignored in single mode and feeds bins and levels in dual mode.
    task automatic test_chip_select();
        t_frame_regs f;
        f = '0;
        for (int c = 0; c < CH_PER_CHIP; c++) begin
            f[0].period[c] = bar_edge[20 + c];
            f[0].amp[c]    = t_amp'(3 + c);
            f[1].period[c] = bar_edge[4 + 3 * c];
            f[1].amp[c]    = t_amp'(20 + 5 * c);
        end
        send_frame(f);
        wait_idle();
        apb_write(ADDR_DUAL_MODE, 32'hFFFF_FFFF);
        apb_read_check(ADDR_DUAL_MODE, 32'd1);
        send_frame(f);
        // Chip 0 louder on channel A and both chips sharing one bin.
        f[0].amp[0]    = 5'd30;
        f[1].period[0] = bar_edge[20];
        send_frame(f);
    endtask

    // A write beyond register zero changes nothing.
    task automatic test_unmapped_register();
        t_frame_regs f;
        wait_idle();
        apb_write(ADDR_UNMAPPED, 32'd0);
        apb_read_check(ADDR_DUAL_MODE, 32'd1);
        f = '0;
        f[1].period[1] = bar_edge[15];
        f[1].amp[1]    = 5'd17;
        send_frame(f);
        wait_idle();
        apb_write(ADDR_DUAL_MODE, 32'hFFFF_FFFE);
        apb_read_check(ADDR_DUAL_MODE, 32'd0);
    endtask

    task automatic test_random_frames(input int send_pct, input int recv_pct,
                                      input logic dual, input int count);
        wait_idle();
        apb_write(ADDR_DUAL_MODE, {31'd0, dual});
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_frame(rand_frame());
    endtask

    initial begin
        int waited;
        build_bar_edges();
        foreach (peak_level[b]) peak_level[b] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_bin_edges();
        test_peak_decay();
        test_chip_select();
        test_unmapped_register();
        test_random_frames(33, 66, 1'b1, 130);
        test_random_frames(66, 33, 1'b0, 130);
        test_random_frames(0, 0, 1'b1, 140);

        // Drain the remaining bars, bounded, then let the block settle.
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (pending_bars.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_bars.size() != 0) begin
            note_fault("bars never delivered", 0, pending_bars.size());
        end

        if (fault_count == 0) begin
            $display("tone_period_bin_meter_unit_tb: done, clean");
        end else begin
            $display("tone_period_bin_meter_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
